// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/irf_pkg.sv =====
// Constants, codes and types of the impulse response FIR filter.
package irf_pkg;
   localparam int MAX_TAPS         = 2048;
   localparam int SAMPLE_BITS      = 24;
   localparam int IDX_BITS         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_BITS         = $clog2(MAX_TAPS + 1);
   localparam int TAP_COUNT_BITS   = 12;
   localparam int COEFF_INDEX_BITS = 11;
   localparam int CMP_BITS         = (CNT_BITS > TAP_COUNT_BITS) ? CNT_BITS : TAP_COUNT_BITS;
   localparam int PROD_BITS        = 2 * SAMPLE_BITS;
   localparam int ACC_BITS         = PROD_BITS + IDX_BITS;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = TAP_COUNT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYPASS    = 1'b1;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEFF  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
endpackage

// ===== rtl/irf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module irf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/impulse_response_fir_filter.sv =====
// A passed-through sample goes from IDLE to EMIT and then to the registered response; a
// filtered sample goes through LOAD, MAC, DRAIN, ROUND and EMIT, one multiply-accumulate
// per tap. A new sample is taken only back in IDLE, as the MAC and the memory read ports
// are shared, and EMIT waits while the response is stalled; coefficient writes are taken
// back to back while idle. After reset the coefficient memory is swept to zero, during
// which no transaction is taken on the input channel; configuration writes still are.
module impulse_response_fir_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  irf_pkg::sample_type                     req_sample_in,
   input  logic [irf_pkg::COEFF_INDEX_BITS-1:0]    req_coeff_index,
   input  irf_pkg::sample_type                     req_coeff_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output irf_pkg::sample_type                     rsp_sample_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [irf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [irf_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import irf_pkg::*;

   `include "assert_macros.svh"

   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(64'sd1 << (SAMPLE_BITS - 2));

   state_type state_ff, state_in;

   logic [IDX_BITS-1:0]       clr_ff, clr_in;
   logic [TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic                      bypass_ff, bypass_in;
   logic [CNT_BITS-1:0]       fill_ff, fill_in;
   logic [IDX_BITS-1:0]       wp_ff, wp_in;
   logic [IDX_BITS-1:0]       pos_ff, pos_in;
   logic [CNT_BITS-1:0]       k_ff, k_in;
   logic [CNT_BITS-1:0]       taps_ff, taps_in;
   sample_type                x_ff, x_in;
   logic                      pass_ff, pass_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      hv_ff, hv_in;
   logic                      prod_valid_ff, prod_valid_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sample_type                rsp_sample_out_ff, rsp_sample_out_in;

   logic                      coef_wr_en;
   logic [IDX_BITS-1:0]       coef_wr_addr;
   logic [SAMPLE_BITS-1:0]    coef_wr_data;
   logic                      hist_wr_en;
   logic [SAMPLE_BITS-1:0]    coef_rd_data;
   logic [SAMPLE_BITS-1:0]    hist_rd_data;

   logic                      req_take;
   logic                      coeff_idx_ok;
   logic [CNT_BITS-1:0]       taps_eff;
   logic                      pass_cond;
   logic                      out_free;
   logic signed [ACC_BITS-1:0] shifted;
   sample_type                 filtered;
   sample_type                 hist_operand;

   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign coeff_idx_ok = CMP_BITS'(req_coeff_index) < CMP_BITS'(MAX_TAPS);
   assign taps_eff  = (CMP_BITS'(tap_count_ff) > CMP_BITS'(MAX_TAPS)) ?
                      CNT_BITS'(MAX_TAPS) : CNT_BITS'(tap_count_ff);
   assign pass_cond = bypass_ff || (taps_eff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Rounding has already been added in the accumulator; the shift floors.
   assign shifted = acc_ff >>> (SAMPLE_BITS - 1);
   always_comb begin
      if (shifted > SAT_HI) begin
         filtered = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         filtered = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         filtered = shifted[SAMPLE_BITS-1:0];
      end
   end

   irf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_addr (k_ff[IDX_BITS-1:0]),
      .rd_data (coef_rd_data)
   );

   irf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_addr (pos_ff),
      .rd_data (hist_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_BITS'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && (req_operation == OP_FILTER)) begin
               state_in = pass_cond ? ST_EMIT : ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_MAC;
         ST_MAC: begin
            if (k_ff == taps_ff - CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !prod_valid_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake and memory write controls
   always_comb begin
      req_ready    = 1'b0;
      coef_wr_en   = 1'b0;
      coef_wr_addr = clr_ff;
      coef_wr_data = '0;
      hist_wr_en   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            coef_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            coef_wr_en   = req_valid && (req_operation == OP_COEFF) && coeff_idx_ok;
            coef_wr_addr = IDX_BITS'(req_coeff_index);
            coef_wr_data = req_coeff_value;
         end
         ST_LOAD: begin
            hist_wr_en = 1'b1;
         end
         default: ;
      endcase
   end

   // Datapath and register next values
   always_comb begin
      clr_in            = clr_ff;
      tap_count_in      = tap_count_ff;
      bypass_in         = bypass_ff;
      fill_in           = fill_ff;
      wp_in             = wp_ff;
      pos_in            = pos_ff;
      k_in              = k_ff;
      taps_in           = taps_ff;
      x_in              = x_ff;
      pass_in           = pass_ff;
      acc_in            = acc_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_out_in = rsp_sample_out_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_TAP_COUNT: tap_count_in = csr_wdata;
            CSR_BYPASS:    bypass_in = csr_wdata[0];
            default: ;
         endcase
      end

      // The MAC pipeline: memory read, then product, then accumulate.
      rd_valid_in   = (state_ff == ST_MAC);
      hv_in         = (state_ff == ST_MAC) && (k_ff < fill_ff);
      prod_valid_in = rd_valid_ff;
      hist_operand  = hv_ff ? sample_type'(hist_rd_data) : '0;
      prod_in       = $signed(coef_rd_data) * hist_operand;
      if (prod_valid_ff) begin
         acc_in = acc_ff + {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IDX_BITS'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               x_in    = req_sample_in;
               pass_in = pass_cond;
               taps_in = taps_eff;
               // A new response starts from a silent history.
               if ((req_operation == OP_COEFF) && coeff_idx_ok) begin
                  fill_in = '0;
                  wp_in   = '0;
               end
            end
         end
         ST_LOAD: begin
            if (fill_ff != CNT_BITS'(MAX_TAPS)) begin
               fill_in = fill_ff + CNT_BITS'(1);
            end
            pos_in = wp_ff;
            wp_in  = (wp_ff == IDX_BITS'(MAX_TAPS - 1)) ? '0 : wp_ff + IDX_BITS'(1);
            k_in   = '0;
            acc_in = '0;
         end
         ST_MAC: begin
            k_in   = k_ff + CNT_BITS'(1);
            pos_in = (pos_ff == '0) ? IDX_BITS'(MAX_TAPS - 1) : pos_ff - IDX_BITS'(1);
         end
         ST_ROUND: begin
            acc_in = acc_ff + ROUND_HALF;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_sample_out_in = pass_ff ? x_ff : filtered;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         tap_count_ff  <= '0;
         bypass_ff     <= 1'b0;
         fill_ff       <= '0;
         wp_ff         <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         tap_count_ff  <= tap_count_in;
         bypass_ff     <= bypass_in;
         fill_ff       <= fill_in;
         wp_ff         <= wp_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      k_ff              <= k_in;
      taps_ff           <= taps_in;
      x_ff              <= x_in;
      pass_ff           <= pass_in;
      hv_ff             <= hv_in;
      prod_ff           <= prod_in;
      acc_ff            <= acc_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   `ASSERT_IMPLIES(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_EMIT))
   `ASSERT_IMPLIES(a_mac_in_range, clock, reset, state_ff == ST_MAC, k_ff < taps_ff)
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_BITS'(MAX_TAPS))
   `ASSERT_IMPLIES(a_idle_pipe_empty, clock, reset, req_ready, !rd_valid_ff && !prod_valid_ff)
endmodule
